// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks on aclk, held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ADR_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ADR_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/adr_pkg.sv =====
// ----------------------------------------------------------------------------
// adr_pkg
// Shared constants and types of the Art-Net DMX receiver.
// ----------------------------------------------------------------------------
package adr_pkg;

    localparam int NUM_OUTPUTS = 4;
    localparam int CHANNELS    = 512;
    localparam int MAX_PACKET  = 530;

    localparam int NUM_CFG      = 4;
    localparam int NUM_OUT_USED = (NUM_OUTPUTS < NUM_CFG) ? NUM_OUTPUTS : NUM_CFG;
    localparam int LANES        = NUM_OUT_USED * 2;
    localparam int LANE_W       = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CH_AW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int UNI_W        = 17;
    localparam int VLEN_W       = 10;
    localparam int IDX_W        = 11;

    localparam logic [IDX_W-1:0] IDX_MAX    = 11'd2047;
    localparam logic [IDX_W-1:0] ID_LEN     = 11'd8;
    localparam logic [IDX_W-1:0] OFS_OP_LO  = 11'd8;
    localparam logic [IDX_W-1:0] OFS_OP_HI  = 11'd9;
    localparam logic [IDX_W-1:0] OFS_UNI_LO = 11'd14;
    localparam logic [IDX_W-1:0] OFS_UNI_HI = 11'd15;
    localparam logic [IDX_W-1:0] OFS_LEN_HI = 11'd16;
    localparam logic [IDX_W-1:0] OFS_LEN_LO = 11'd17;
    localparam logic [IDX_W-1:0] DATA_START = 11'd18;
    localparam logic [IDX_W-1:0] POLL_MIN   = 11'd10;

    localparam logic [15:0] OP_DMX  = 16'h5000;
    localparam logic [15:0] OP_POLL = 16'h2000;

    localparam logic [7:0] ART_ID [8] = '{8'h41, 8'h72, 8'h74, 8'h2D,
                                         8'h4E, 8'h65, 8'h74, 8'h00};

    typedef enum logic {
        REQ_PACKET = 1'b0,
        REQ_READ   = 1'b1
    } req_t;

    typedef enum logic {
        KIND_READ   = 1'b0,
        KIND_PACKET = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        OUT_IGNORED = 2'd0,
        OUT_DMX     = 2'd1,
        OUT_POLL    = 2'd2
    } outcome_t;

    typedef struct packed {
        logic             hdr_good;
        logic [15:0]      op;
        logic [15:0]      len;
        logic [3:0]       match;
        logic [IDX_W-1:0] total;
        logic             data_we;
        logic [CH_AW-1:0] data_addr;
    } parse_t;

endpackage

// ===== rtl/adr_hdr_parse.sv =====
// ----------------------------------------------------------------------------
// adr_hdr_parse
// Byte counter and header decoder: identifier check, opcode, universe,
// length, output match and data channel address of each packet word.
// ----------------------------------------------------------------------------
module adr_hdr_parse (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          byte_en,
    input  logic [7:0]                                    pkt_byte,
    input  logic                                          pkt_last,
    input  logic [adr_pkg::NUM_CFG-1:0][adr_pkg::UNI_W-1:0] universe,
    output adr_pkg::parse_t                               pr
);

    logic [adr_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      hdr_good_reg, hdr_good_next;
    logic [15:0]               op_reg, op_next;
    logic [15:0]               uni_reg, uni_next;
    logic [15:0]               len_reg, len_next;
    logic [3:0]                match_reg, match_next;
    logic [adr_pkg::IDX_W-1:0] data_off;
    logic                      data_we;

    always_comb begin
        hdr_good_next = hdr_good_reg;
        op_next       = op_reg;
        uni_next      = uni_reg;
        len_next      = len_reg;
        match_next    = match_reg;
        data_we       = 1'b0;
        data_off      = idx_reg - adr_pkg::DATA_START;
        if (idx_reg < adr_pkg::ID_LEN) begin
            if (pkt_byte != adr_pkg::ART_ID[idx_reg[2:0]]) begin
                hdr_good_next = 1'b0;
            end
        end else begin
            case (idx_reg)
                adr_pkg::OFS_OP_LO:  op_next  = {op_reg[15:8], pkt_byte};
                adr_pkg::OFS_OP_HI:  op_next  = {pkt_byte, op_reg[7:0]};
                adr_pkg::OFS_UNI_LO: uni_next = {uni_reg[15:8], pkt_byte};
                adr_pkg::OFS_UNI_HI: begin
                    uni_next   = {pkt_byte, uni_reg[7:0]};
                    match_next = 4'd0;
                    for (int o = 0; o < adr_pkg::NUM_OUT_USED; o++) begin
                        if (!universe[o][adr_pkg::UNI_W-1] &&
                            universe[o][15:0] == {pkt_byte, uni_reg[7:0]}) begin
                            match_next[o] = 1'b1;
                        end
                    end
                end
                adr_pkg::OFS_LEN_HI: len_next = {pkt_byte, len_reg[7:0]};
                adr_pkg::OFS_LEN_LO: len_next = {len_reg[15:8], pkt_byte};
                default: begin
                    if (idx_reg >= adr_pkg::DATA_START &&
                        data_off < adr_pkg::IDX_W'(adr_pkg::CHANNELS)) begin
                        data_we = 1'b1;
                    end
                end
            endcase
        end
        idx_next = (idx_reg < adr_pkg::IDX_MAX) ? idx_reg + 1'b1 : idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            hdr_good_reg <= 1'b1;
            op_reg       <= '0;
            uni_reg      <= '0;
            len_reg      <= '0;
            match_reg    <= '0;
        end else if (byte_en) begin
            if (pkt_last) begin
                idx_reg      <= '0;
                hdr_good_reg <= 1'b1;
                op_reg       <= '0;
                uni_reg      <= '0;
                len_reg      <= '0;
                match_reg    <= '0;
            end else begin
                idx_reg      <= idx_next;
                hdr_good_reg <= hdr_good_next;
                op_reg       <= op_next;
                uni_reg      <= uni_next;
                len_reg      <= len_next;
                match_reg    <= match_next;
            end
        end
    end

    always_comb begin
        pr.hdr_good  = hdr_good_next;
        pr.op        = op_next;
        pr.len       = len_next;
        pr.match     = match_next;
        pr.total     = idx_next;
        pr.data_we   = data_we;
        pr.data_addr = data_off[adr_pkg::CH_AW-1:0];
    end

endmodule

// ===== rtl/artnet_dmx_receiver.sv =====
// ----------------------------------------------------------------------------
// artnet_dmx_receiver
// Art-Net ArtDmx / ArtPoll receiver with double-buffered DMX channel store.
// ----------------------------------------------------------------------------
// Takes one word per clock, packet bytes and channel reads mixed freely, with
// no gaps. A read word gives one result; a final packet byte gives one outcome
// result; other packet bytes give none. Results pass a store read stage and an
// output register, so the input keeps moving while one result waits, and
// stalls only when both stages are full and m_ready is low. Channel data sit
// in one 512 x 64 single-port-write, single-read store, one byte lane per
// output and bank, written in parallel for all matching outputs; bank swap
// and valid lengths are flip-flops.
`include "assert_macros.svh"

module artnet_dmx_receiver (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_addr,
    input  logic [adr_pkg::UNI_W-1:0]   cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [7:0]                  s_pkt_byte,
    input  logic                        s_pkt_last,
    input  logic                        s_to_broadcast,
    input  logic [1:0]                  s_read_output,
    input  logic [8:0]                  s_read_channel,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_result_kind,
    output logic [7:0]                  m_read_value,
    output logic [1:0]                  m_packet_outcome,
    output logic [3:0]                  m_outputs_updated
);

    localparam int LW = adr_pkg::LANES * 8;

    logic [adr_pkg::NUM_CFG-1:0][adr_pkg::UNI_W-1:0] universe_reg;
    logic [adr_pkg::NUM_OUT_USED-1:0]                active_bank_reg, active_bank_next;
    logic [adr_pkg::VLEN_W-1:0] vlen_reg [adr_pkg::NUM_OUT_USED][2];
    logic [LW-1:0]              store [adr_pkg::CHANNELS];
    logic [LW-1:0]              rd_word_reg;

    adr_pkg::parse_t            pr;
    logic                       accept, is_read, byte_acc, res_new;
    logic                       pkt_ok, is_dmx, is_poll;
    logic [adr_pkg::IDX_W-1:0]  data_cnt;
    logic [15:0]                len_min;
    logic [adr_pkg::VLEN_W-1:0] vlen_new;
    adr_pkg::outcome_t          outcome;
    logic [3:0]                 updated;
    logic [adr_pkg::LANES-1:0]  lane_we;
    logic                       rd_ok;
    logic [adr_pkg::LANE_W-1:0] rd_lane;
    logic [adr_pkg::VLEN_W-1:0] rd_vlen;

    logic                       p1_v_reg, p2_v_reg, p1_move, p2_free;
    adr_pkg::kind_t             p1_kind_reg, p2_kind_reg;
    adr_pkg::outcome_t          p1_outcome_reg, p2_outcome_reg;
    logic [3:0]                 p1_upd_reg, p2_upd_reg;
    logic                       p1_ok_reg;
    logic [adr_pkg::LANE_W-1:0] p1_lane_reg;
    logic [7:0]                 p2_value_reg;

    adr_hdr_parse u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .byte_en  (byte_acc),
        .pkt_byte (s_pkt_byte),
        .pkt_last (s_pkt_last),
        .universe (universe_reg),
        .pr       (pr)
    );

    assign p2_free = !p2_v_reg || m_ready;
    assign p1_move = p1_v_reg && p2_free;
    assign s_ready = !p1_v_reg || p2_free;
    assign accept  = s_valid && s_ready;
    assign is_read = (s_req_type == adr_pkg::REQ_READ);
    assign byte_acc = accept && !is_read;
    assign res_new  = accept && (is_read || s_pkt_last);

    always_comb begin
        pkt_ok   = (pr.total <= adr_pkg::IDX_W'(adr_pkg::MAX_PACKET)) && pr.hdr_good;
        is_dmx   = pkt_ok && pr.op == adr_pkg::OP_DMX && !s_to_broadcast &&
                   pr.total >= adr_pkg::DATA_START;
        is_poll  = pkt_ok && pr.op == adr_pkg::OP_POLL && s_to_broadcast &&
                   pr.total >= adr_pkg::POLL_MIN;
        data_cnt = pr.total - adr_pkg::DATA_START;
        len_min  = (pr.len < 16'(data_cnt)) ? pr.len : 16'(data_cnt);
        vlen_new = (len_min < 16'(adr_pkg::CHANNELS)) ?
                   len_min[adr_pkg::VLEN_W-1:0] : adr_pkg::VLEN_W'(adr_pkg::CHANNELS);
        outcome  = is_dmx ? adr_pkg::OUT_DMX :
                   (is_poll ? adr_pkg::OUT_POLL : adr_pkg::OUT_IGNORED);
        updated  = is_dmx ? pr.match : 4'd0;
        active_bank_next = active_bank_reg;
        for (int o = 0; o < adr_pkg::NUM_OUT_USED; o++) begin
            if (byte_acc && s_pkt_last && is_dmx && pr.match[o]) begin
                active_bank_next[o] = !active_bank_reg[o];
            end
            lane_we[o*2]   = byte_acc && pr.data_we && pr.match[o] && active_bank_reg[o];
            lane_we[o*2+1] = byte_acc && pr.data_we && pr.match[o] && !active_bank_reg[o];
        end
    end

    always_comb begin
        rd_vlen = '0;
        rd_lane = '0;
        for (int o = 0; o < adr_pkg::NUM_OUT_USED; o++) begin
            if (s_read_output == 2'(o)) begin
                rd_vlen = vlen_reg[o][active_bank_reg[o]];
                rd_lane = adr_pkg::LANE_W'(o * 2) + adr_pkg::LANE_W'(active_bank_reg[o]);
            end
        end
        rd_ok = (32'(s_read_output) < adr_pkg::NUM_OUT_USED) &&
                ({1'b0, s_read_channel} < 10'(adr_pkg::CHANNELS)) &&
                ({1'b0, s_read_channel} < 10'(rd_vlen));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            universe_reg    <= {adr_pkg::NUM_CFG{{adr_pkg::UNI_W{1'b1}}}};
            active_bank_reg <= '0;
            for (int o = 0; o < adr_pkg::NUM_OUT_USED; o++) begin
                vlen_reg[o][0] <= '0;
                vlen_reg[o][1] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                universe_reg[cfg_addr] <= cfg_wdata;
            end
            active_bank_reg <= active_bank_next;
            for (int o = 0; o < adr_pkg::NUM_OUT_USED; o++) begin
                if (byte_acc && s_pkt_last && is_dmx && pr.match[o]) begin
                    vlen_reg[o][!active_bank_reg[o]] <= vlen_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int l = 0; l < adr_pkg::LANES; l++) begin
            if (lane_we[l]) begin
                store[pr.data_addr][l*8 +: 8] <= s_pkt_byte;
            end
        end
        if (accept && is_read) begin
            rd_word_reg <= store[s_read_channel[adr_pkg::CH_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
        end else begin
            if (res_new) begin
                p1_v_reg <= 1'b1;
            end else if (p1_move) begin
                p1_v_reg <= 1'b0;
            end
            if (p1_move) begin
                p2_v_reg <= 1'b1;
            end else if (m_ready) begin
                p2_v_reg <= 1'b0;
            end
        end
        if (res_new) begin
            p1_kind_reg    <= is_read ? adr_pkg::KIND_READ : adr_pkg::KIND_PACKET;
            p1_outcome_reg <= is_read ? adr_pkg::OUT_IGNORED : outcome;
            p1_upd_reg     <= is_read ? 4'd0 : updated;
            p1_ok_reg      <= is_read && rd_ok;
            p1_lane_reg    <= rd_lane;
        end
        if (p1_move) begin
            p2_kind_reg    <= p1_kind_reg;
            p2_outcome_reg <= p1_outcome_reg;
            p2_upd_reg     <= p1_upd_reg;
            p2_value_reg   <= p1_ok_reg ? rd_word_reg[p1_lane_reg*8 +: 8] : 8'd0;
        end
    end

    assign m_valid           = p2_v_reg;
    assign m_result_kind     = p2_kind_reg;
    assign m_read_value      = p2_value_reg;
    assign m_packet_outcome  = p2_outcome_reg;
    assign m_outputs_updated = p2_upd_reg;

    `ADR_ASSERT_IMP(a_upd_only_dmx, m_valid && m_outputs_updated != 4'd0,
        m_packet_outcome == adr_pkg::OUT_DMX, "update mask without DMX outcome")
    `ADR_ASSERT_IMP(a_read_clean, m_valid && m_result_kind == adr_pkg::KIND_READ,
        m_packet_outcome == adr_pkg::OUT_IGNORED && m_outputs_updated == 4'd0,
        "read result carries packet fields")
    `ADR_ASSERT_IMP(a_full_stall, p1_v_reg && p2_v_reg && !m_ready, !s_ready,
        "input taken with both result stages full")
    `ADR_ASSERT_NXT(a_bank_flip, byte_acc && s_pkt_last && is_dmx && pr.match[0],
        active_bank_reg[0] != $past(active_bank_reg[0]), "bank of output 0 not swapped")

endmodule
